// ----- src/dlf_pkg.sv -----
// shared types, register codes and reset values for the delimited line framer
package dlf_pkg;

  localparam int LINE_LIMIT_DEF = 63;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR_A   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_A_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_B_ENABLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 3'd6;

  localparam logic [7:0]  START_CHAR_RST    = 8'h24;
  localparam logic [7:0]  END_CHAR_RST      = 8'h0a;
  localparam logic [7:0]  IGNORE_CHAR_A_RST = 8'h0d;
  localparam logic        IGNORE_A_EN_RST   = 1'b1;
  localparam logic [7:0]  IGNORE_CHAR_B_RST = 8'h00;
  localparam logic        IGNORE_B_EN_RST   = 1'b0;
  localparam logic [15:0] TIMEOUT_RST       = 16'd1000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_OUT,
    S_ERR
  } state_t;

endpackage

// ----- src/dlf_ram.sv -----
// generic single-port-write ram with registered read
module dlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/delimited_line_framer.sv -----
// delimited line framer top level: sentence tracking, line store and line drain
//
// Each received byte or idle tick is taken while the block is in S_IDLE, not
// draining or reporting an error. A closing byte that ends a non-empty line,
// or a line that grows past LINE_LIMIT bytes, starts a drain that reads the
// line store, a ram with registered read, byte by byte through S_RD and S_OUT
// and holds the input until the line is out, plus any output back-pressure.
// A timeout error holds the input until its error beat is sent; after it every
// beat is taken and dropped until reset. Configuration writes are taken at any time and apply to the next byte.
module delimited_line_framer #(
  parameter int LINE_LIMIT = dlf_pkg::LINE_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [7:0]                   out_line_byte,
  output logic                         out_last_of_line,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = LINE_LIMIT + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(LINE_LIMIT + 2);

  logic [7:0]  start_char_r, end_char_r, ign_a_r, ign_b_r;
  logic        ign_a_en_r, ign_b_en_r;
  logic [15:0] timeout_r;

  dlf_pkg::state_t state_r, state_nxt;
  logic             in_sentence_r, in_sentence_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic             halted_r, halted_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic              in_acc;
  logic              start_hit, sent_eff, ignored, store_en, out_free, last_rd;
  logic [LEN_W-1:0]  len_eff, len_new;
  logic [16:0]       idle_inc;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= dlf_pkg::START_CHAR_RST;
      end_char_r   <= dlf_pkg::END_CHAR_RST;
      ign_a_r      <= dlf_pkg::IGNORE_CHAR_A_RST;
      ign_a_en_r   <= dlf_pkg::IGNORE_A_EN_RST;
      ign_b_r      <= dlf_pkg::IGNORE_CHAR_B_RST;
      ign_b_en_r   <= dlf_pkg::IGNORE_B_EN_RST;
      timeout_r    <= dlf_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlf_pkg::CFG_START_CHAR:      start_char_r <= cfg_data[7:0];
        dlf_pkg::CFG_END_CHAR:        end_char_r   <= cfg_data[7:0];
        dlf_pkg::CFG_IGNORE_CHAR_A:   ign_a_r      <= cfg_data[7:0];
        dlf_pkg::CFG_IGNORE_A_ENABLE: ign_a_en_r   <= cfg_data[0];
        dlf_pkg::CFG_IGNORE_CHAR_B:   ign_b_r      <= cfg_data[7:0];
        dlf_pkg::CFG_IGNORE_B_ENABLE: ign_b_en_r   <= cfg_data[0];
        dlf_pkg::CFG_TIMEOUT_TICKS:   timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == dlf_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign start_hit = (in_rx_byte == start_char_r);
  assign sent_eff  = in_sentence_r || start_hit;
  assign len_eff   = start_hit ? '0 : len_r;
  assign ignored   = (ign_a_en_r && in_rx_byte == ign_a_r) ||
                     (ign_b_en_r && in_rx_byte == ign_b_r);
  assign store_en  = !ignored && (len_eff < LEN_W'(DEPTH));
  assign len_new   = len_eff + LEN_W'(store_en);
  assign idle_inc  = {1'b0, idle_r} + 17'd1;
  assign last_rd   = (LEN_W'(rd_idx_r) + LEN_W'(1)) == len_r;

  assign ram_waddr = len_eff[ADDR_W-1:0];
  assign ram_we    = in_acc && !halted_r && in_command == dlf_pkg::CMD_BYTE &&
                     sent_eff && (in_rx_byte != end_char_r) && store_en;
  assign ram_re    = (state_r == dlf_pkg::S_RD);

  dlf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    in_sentence_nxt = in_sentence_r;
    len_nxt         = len_r;
    idle_nxt        = idle_r;
    halted_nxt      = halted_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      dlf_pkg::S_IDLE: begin
        if (in_acc && !halted_r) begin
          if (in_command == dlf_pkg::CMD_IDLE) begin
            idle_nxt = idle_inc[15:0];
            if (idle_inc >= {1'b0, timeout_r}) begin
              halted_nxt      = 1'b1;
              in_sentence_nxt = 1'b0;
              len_nxt         = '0;
              state_nxt       = dlf_pkg::S_ERR;
            end
          end else begin
            idle_nxt = '0;
            if (sent_eff) begin
              if (in_rx_byte == end_char_r) begin
                in_sentence_nxt = 1'b0;
                len_nxt         = len_eff;
                rd_idx_nxt      = '0;
                if (len_eff != '0) begin
                  state_nxt = dlf_pkg::S_RD;
                end
              end else if (len_new > LEN_W'(LINE_LIMIT)) begin
                in_sentence_nxt = 1'b0;
                len_nxt         = len_new;
                rd_idx_nxt      = '0;
                state_nxt       = dlf_pkg::S_RD;
              end else begin
                in_sentence_nxt = 1'b1;
                len_nxt         = len_new;
              end
            end
          end
        end
      end
      dlf_pkg::S_RD: begin
        state_nxt = dlf_pkg::S_OUT;
      end
      dlf_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = dlf_pkg::KIND_BYTE;
          out_byte_nxt  = ram_rdata;
          out_last_nxt  = last_rd;
          if (last_rd) begin
            len_nxt   = '0;
            state_nxt = dlf_pkg::S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            state_nxt  = dlf_pkg::S_RD;
          end
        end
      end
      dlf_pkg::S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = dlf_pkg::KIND_ERROR;
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = dlf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dlf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dlf_pkg::S_IDLE;
      in_sentence_r <= 1'b0;
      len_r         <= '0;
      idle_r        <= '0;
      halted_r      <= 1'b0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      in_sentence_r <= in_sentence_nxt;
      len_r         <= len_nxt;
      idle_r        <= idle_nxt;
      halted_r      <= halted_nxt;
      rd_idx_r      <= rd_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_line_byte    = out_byte_r;
  assign out_last_of_line = out_last_r;

endmodule

// ----- tb/dlf_line_checker.sv -----
// line checker: predicts the framer's output beats from accepted input and compares them
module dlf_line_checker #(
  parameter int LINE_LIMIT = dlf_pkg::LINE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_command,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_kind,
  input  logic [7:0]                     out_line_byte,
  input  logic                           out_last_of_line,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } line_beat_t;

  logic [7:0]  start_q;
  logic [7:0]  end_q;
  logic [7:0]  ign_a_q;
  logic        ign_a_en_q;
  logic [7:0]  ign_b_q;
  logic        ign_b_en_q;
  logic [15:0] timeout_q;

  logic        open_q;
  logic [6:0]  fill_q;
  logic [7:0]  line_mem [STORE_DEPTH];
  logic [15:0] idle_q;
  logic        halted_q;

  line_beat_t  expected_beats [$];

  function automatic void flush_line();
    line_beat_t beat;
    for (int k = 0; k < int'(fill_q); k++) begin
      beat.kind = dlf_pkg::KIND_BYTE;
      beat.data = line_mem[k];
      beat.last = (k + 1 == int'(fill_q));
      expected_beats.push_back(beat);
    end
    fill_q = '0;
    open_q = 1'b0;
  endfunction

  function automatic void frame_item(input logic cmd, input logic [7:0] b);
    logic [16:0] next_idle;
    line_beat_t  beat;
    if (halted_q) return;
    if (cmd == dlf_pkg::CMD_IDLE) begin
      next_idle = {1'b0, idle_q} + 17'd1;
      if (next_idle >= {1'b0, timeout_q}) begin
        halted_q = 1'b1;
        open_q = 1'b0;
        fill_q = '0;
        idle_q = next_idle[16] ? 16'hffff : next_idle[15:0];
        beat.kind = dlf_pkg::KIND_ERROR;
        beat.data = 8'h00;
        beat.last = 1'b1;
        expected_beats.push_back(beat);
      end else begin
        idle_q = next_idle[15:0];
      end
      return;
    end
    idle_q = '0;
    if (b == start_q) begin
      open_q = 1'b1;
      fill_q = '0;
    end
    if (!open_q) return;
    if (b == end_q) begin
      flush_line();
      return;
    end
    if (!((ign_a_en_q && b == ign_a_q) || (ign_b_en_q && b == ign_b_q)) &&
        int'(fill_q) < STORE_DEPTH) begin
      line_mem[fill_q[5:0]] = b;
      fill_q = fill_q + 7'd1;
    end
    if (int'(fill_q) > LINE_LIMIT || int'(fill_q) >= STORE_DEPTH) flush_line();
  endfunction

  function automatic void note_fault(input string what, input line_beat_t want,
                                     input line_beat_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
               what, want.kind, want.data, want.last, got.kind, got.data, got.last);
    end
  endfunction

  always @(posedge clk) begin
    line_beat_t got;
    line_beat_t want;
    if (!rst_n) begin
      start_q    = dlf_pkg::START_CHAR_RST;
      end_q      = dlf_pkg::END_CHAR_RST;
      ign_a_q    = dlf_pkg::IGNORE_CHAR_A_RST;
      ign_a_en_q = dlf_pkg::IGNORE_A_EN_RST;
      ign_b_q    = dlf_pkg::IGNORE_CHAR_B_RST;
      ign_b_en_q = dlf_pkg::IGNORE_B_EN_RST;
      timeout_q  = dlf_pkg::TIMEOUT_RST;
      open_q     = 1'b0;
      fill_q     = '0;
      idle_q     = '0;
      halted_q   = 1'b0;
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dlf_pkg::CFG_START_CHAR:      start_q    = cfg_data[7:0];
          dlf_pkg::CFG_END_CHAR:        end_q      = cfg_data[7:0];
          dlf_pkg::CFG_IGNORE_CHAR_A:   ign_a_q    = cfg_data[7:0];
          dlf_pkg::CFG_IGNORE_A_ENABLE: ign_a_en_q = cfg_data[0];
          dlf_pkg::CFG_IGNORE_CHAR_B:   ign_b_q    = cfg_data[7:0];
          dlf_pkg::CFG_IGNORE_B_ENABLE: ign_b_en_q = cfg_data[0];
          dlf_pkg::CFG_TIMEOUT_TICKS:   timeout_q  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) frame_item(in_command, in_rx_byte);
      if (out_valid && out_ready) begin
        got.kind = out_kind;
        got.data = out_line_byte;
        got.last = out_last_of_line;
        if (expected_beats.size() == 0) begin
          note_fault("unexpected beat", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) note_fault("beat mismatch", want, got);
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ----- tb/delimited_line_framer_test.sv -----
// testbench top: drives framed serial traffic and idle ticks into the framer and gives the verdict
module delimited_line_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 40;
  localparam int TOTAL_ITEMS  = 330;

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           in_valid         = 1'b0;
  logic                           in_ready;
  logic                           in_command       = dlf_pkg::CMD_BYTE;
  logic [7:0]                     in_rx_byte       = 8'h00;
  logic                           out_valid;
  logic                           out_ready        = 1'b0;
  logic                           out_kind;
  logic [7:0]                     out_line_byte;
  logic                           out_last_of_line;
  logic                           cfg_valid        = 1'b0;
  logic                           cfg_ready;
  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index        = dlf_pkg::CFG_START_CHAR;
  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_data         = '0;

  int fail_count;
  int pending_beats;
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_run    = 0;

  logic [7:0]  cur_start   = dlf_pkg::START_CHAR_RST;
  logic [7:0]  cur_end     = dlf_pkg::END_CHAR_RST;
  logic [7:0]  cur_ign_a   = dlf_pkg::IGNORE_CHAR_A_RST;
  logic [7:0]  cur_ign_b   = dlf_pkg::IGNORE_CHAR_B_RST;
  logic [15:0] cur_timeout = dlf_pkg::TIMEOUT_RST;

  logic [7:0] stall_pat = 8'h00;
  int         pat_left  = 0;

  always #HALF_PERIOD clk = ~clk;

  delimited_line_framer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_line_byte    (out_line_byte),
    .out_last_of_line (out_last_of_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  dlf_line_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_line_byte    (out_line_byte),
    .out_last_of_line (out_last_of_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending_beats)
  );

  // receiver stall pattern, rotated every cycle, swapped now and then
  always @(negedge clk) begin
    if (pat_left == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'h00 : (8'($urandom) & 8'h7f);
      pat_left = $urandom_range(50, 300);
    end else begin
      pat_left--;
    end
    stall_pat = {stall_pat[0], stall_pat[7:1]};
    out_ready = ~stall_pat[0];
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input logic cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_command = cmd;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (cmd == dlf_pkg::CMD_IDLE) idle_run++;
    else idle_run = 0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dlf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper data bits carry junk on the narrow registers
  task automatic apply_setting(input logic [7:0] s, input logic [7:0] e,
                               input logic [7:0] ia, input logic ea,
                               input logic [7:0] ib, input logic eb,
                               input logic [15:0] to);
    wait_drained();
    write_reg(dlf_pkg::CFG_START_CHAR,      {8'($urandom), s});
    write_reg(dlf_pkg::CFG_END_CHAR,        {8'($urandom), e});
    write_reg(dlf_pkg::CFG_IGNORE_CHAR_A,   {8'($urandom), ia});
    write_reg(dlf_pkg::CFG_IGNORE_A_ENABLE, {15'($urandom), ea});
    write_reg(dlf_pkg::CFG_IGNORE_CHAR_B,   {8'($urandom), ib});
    write_reg(dlf_pkg::CFG_IGNORE_B_ENABLE, {15'($urandom), eb});
    write_reg(dlf_pkg::CFG_TIMEOUT_TICKS,   to);
    cur_start   = s;
    cur_end     = e;
    cur_ign_a   = ia;
    cur_ign_b   = ib;
    cur_timeout = to;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == cur_start || b == cur_end) b = b + 8'd1;
    return b;
  endfunction

  // keep idle runs short of the timeout until the final phase
  function automatic bit tick_ok();
    return (idle_run + 1 < int'(cur_timeout));
  endfunction

  task automatic send_sentence(input int len);
    int r;
    send_beat(dlf_pkg::CMD_BYTE, cur_start);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0 && tick_ok()) send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
      else if (r == 1) send_beat(dlf_pkg::CMD_BYTE, cur_ign_a);
      else if (r == 2) send_beat(dlf_pkg::CMD_BYTE, cur_ign_b);
      else if (r == 3 && len < 20) send_beat(dlf_pkg::CMD_BYTE, cur_start);
      send_beat(dlf_pkg::CMD_BYTE, plain_byte());
    end
    if ($urandom_range(0, 11) != 0) send_beat(dlf_pkg::CMD_BYTE, cur_end);
  endtask

  task automatic send_noise(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0 && tick_ok()) begin
        send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
      end else if ($urandom_range(0, 3) == 0) begin
        send_beat(dlf_pkg::CMD_BYTE, 8'($urandom));
      end else begin
        send_beat(dlf_pkg::CMD_BYTE, plain_byte());
      end
    end
  endtask

  task automatic run_random(input int n);
    int target;
    int r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        if ($urandom_range(0, 11) == 0) send_sentence($urandom_range(58, 70));
        else send_sentence($urandom_range(0, 10));
      end else if (r < 18) begin
        send_noise($urandom_range(1, 4));
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    logic [7:0]  s;
    logic [7:0]  e;
    logic [15:0] to;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: bytes outside a sentence, ignore byte, restart, start byte stored
    send_beat(dlf_pkg::CMD_BYTE, 8'h41);
    send_beat(dlf_pkg::CMD_IDLE, 8'hff);
    send_beat(dlf_pkg::CMD_BYTE, 8'h0a);
    send_beat(dlf_pkg::CMD_BYTE, 8'h24);
    send_beat(dlf_pkg::CMD_BYTE, 8'h00);
    send_beat(dlf_pkg::CMD_BYTE, 8'hff);
    send_beat(dlf_pkg::CMD_BYTE, 8'h0d);
    send_beat(dlf_pkg::CMD_IDLE, 8'h00);
    send_beat(dlf_pkg::CMD_BYTE, 8'h80);
    send_beat(dlf_pkg::CMD_BYTE, 8'h0a);
    send_beat(dlf_pkg::CMD_BYTE, 8'h24);
    send_beat(dlf_pkg::CMD_BYTE, 8'h0a);
    send_beat(dlf_pkg::CMD_BYTE, 8'h24);
    send_beat(dlf_pkg::CMD_BYTE, 8'h41);
    send_beat(dlf_pkg::CMD_BYTE, 8'h24);
    send_beat(dlf_pkg::CMD_BYTE, 8'h42);
    send_beat(dlf_pkg::CMD_BYTE, 8'h0a);
    send_beat(dlf_pkg::CMD_BYTE, 8'h24);
    send_beat(dlf_pkg::CMD_BYTE, 8'h00);
    send_beat(dlf_pkg::CMD_BYTE, 8'h0a);
    run_random(70);

    // extreme delimiters, both ignore bytes on, longest timeout
    apply_setting(8'h00, 8'hff, 8'h7f, 1'b1, 8'h80, 1'b1, 16'hffff);
    run_random(70);

    // start equal to end: every sentence closes empty
    s = 8'($urandom);
    apply_setting(s, s, 8'($urandom), 1'b0, 8'($urandom), 1'b0, 16'd1);
    send_beat(dlf_pkg::CMD_BYTE, s);
    send_beat(dlf_pkg::CMD_BYTE, plain_byte());
    send_beat(dlf_pkg::CMD_BYTE, s);
    run_random(30);

    // start byte ignored, so empty lines appear
    s = 8'($urandom);
    e = s ^ 8'($urandom_range(1, 255));
    apply_setting(s, e, s, 1'b1, 8'($urandom), 1'b1, 16'($urandom_range(2, 20)));
    send_beat(dlf_pkg::CMD_BYTE, s);
    send_beat(dlf_pkg::CMD_BYTE, e);
    send_beat(dlf_pkg::CMD_BYTE, s);
    send_beat(dlf_pkg::CMD_BYTE, plain_byte());
    send_beat(dlf_pkg::CMD_BYTE, e);
    run_random(70);

    while (items_sent < TOTAL_ITEMS) begin
      s = 8'($urandom);
      e = ($urandom_range(0, 7) == 0) ? s : 8'($urandom);
      case ($urandom_range(0, 2))
        0: to = 16'd1;
        1: to = 16'hffff;
        default: to = 16'($urandom_range(2, 40));
      endcase
      apply_setting(s, e, ($urandom_range(0, 3) == 0) ? s : 8'($urandom), 1'($urandom),
                    8'($urandom), 1'($urandom), to);
      run_random(60);
    end

    // timeout with a line in progress, then everything is dropped
    s = 8'($urandom);
    e = s ^ 8'($urandom_range(1, 255));
    to = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd3;
    apply_setting(s, e, 8'($urandom), 1'b0, 8'($urandom), 1'b0, to);
    send_beat(dlf_pkg::CMD_BYTE, s);
    send_beat(dlf_pkg::CMD_BYTE, plain_byte());
    if (to != 16'd0) begin
      send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
      send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
      send_beat(dlf_pkg::CMD_BYTE, plain_byte());
      send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
      send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
    end
    send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));
    send_beat(dlf_pkg::CMD_BYTE, s);
    send_beat(dlf_pkg::CMD_BYTE, plain_byte());
    send_beat(dlf_pkg::CMD_BYTE, e);
    send_beat(dlf_pkg::CMD_IDLE, 8'($urandom));

    wait_drained();
    if (fail_count == 0 && pending_beats == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
